[src/assert_macros.svh]
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled during reset.
`define CCSP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that holds at every edge, reset included.
`define CCSP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ccsp_pkg.sv]
// Package: payload types, capacity constants, byte classes and the sequencer microcode.
package ccsp_pkg;

	localparam int MAX_LEN = 64;
	localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW      = $clog2(MAX_LEN + 1);

	typedef struct packed {
		logic [7:0] char_in;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_out;
		logic       truncated;
	} out_item_t;

	typedef enum logic [1:0] {
		CLS_DIGIT  = 2'd0,
		CLS_LETTER = 2'd1,
		CLS_OTHER  = 2'd2
	} cls_t;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;

	function automatic cls_t class_of(input logic [7:0] b);
		if (b >= CH_0 && b <= CH_9)
			return CLS_DIGIT;
		if ((b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ))
			return CLS_LETTER;
		return CLS_OTHER;
	endfunction

	typedef enum logic [1:0] {
		ST_LOAD  = 2'd0,
		ST_READ  = 2'd1,
		ST_TEST  = 2'd2,
		ST_PEND  = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		C_FINAL_IN  = 2'd0,
		C_SCAN_END  = 2'd1,
		C_OUT_BLOCK = 2'd2,
		C_LAST_PASS = 2'd3
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  issue_rd;
		logic  test;
		logic  end_pass;
		cond_t cond;
		step_t jmp_tgt;
		step_t nxt_tgt;
	} uword_t;

	// Microcode ROM: jump to jmp_tgt when cond holds, else go to nxt_tgt.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '0;
		case (s)
			ST_LOAD: begin
				w.take_in = 1'b1;
				w.cond    = C_FINAL_IN;
				w.jmp_tgt = ST_READ;
				w.nxt_tgt = ST_LOAD;
			end
			ST_READ: begin
				w.issue_rd = 1'b1;
				w.cond     = C_SCAN_END;
				w.jmp_tgt  = ST_PEND;
				w.nxt_tgt  = ST_TEST;
			end
			ST_TEST: begin
				w.test    = 1'b1;
				w.cond    = C_OUT_BLOCK;
				w.jmp_tgt = ST_TEST;
				w.nxt_tgt = ST_READ;
			end
			ST_PEND: begin
				w.end_pass = 1'b1;
				w.cond     = C_LAST_PASS;
				w.jmp_tgt  = ST_LOAD;
				w.nxt_tgt  = ST_READ;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

[src/char_class_stable_partition_core.sv]
// Top level: byte string store with three-pass digit/letter/other regrouping.
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data    | in_valid && in_ready
//  out     | out_valid, out_ready, out_data | out_valid && out_ready
//
// Loading accepts one byte per cycle; in_ready is high only in the load step.
// After the final byte, three scans of the store run: a memory read and a
// class test per stored byte and pass, then the closing read and the pass step
// at each pass end; the scans share the single read port.
// A result waits in the output register; a stall holds the test step.
// Reset clears the sequencer, counters and the output valid; the store needs none.
`include "assert_macros.svh"

module char_class_stable_partition_core
	import ccsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [7:0]    byte_mem [MAX_LEN];
	logic [7:0]    rd_q;
	step_t         step_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] emit_q;
	logic [1:0]    pass_q;
	logic          ovf_q;
	logic          out_valid_q;
	out_item_t     out_q;

	uword_t        uw;
	logic          in_xfer;
	logic          scan_end;
	logic          blocked;
	logic          match;
	logic          load_out;
	logic          nxt_last;
	logic          cond_hit;
	logic          store_wr;

	assign uw       = ucode(step_q);
	assign in_ready = uw.take_in;
	assign in_xfer  = in_valid && uw.take_in;
	assign store_wr = in_xfer && (fill_q < CW'(MAX_LEN));
	assign scan_end = (idx_q == fill_q);
	assign blocked  = out_valid_q && !out_ready;
	assign match    = (2'(class_of(rd_q)) == pass_q);
	assign load_out = uw.test && match && !blocked;
	assign nxt_last = ((emit_q + CW'(1)) == fill_q);

	always_comb begin
		case (uw.cond)
			C_FINAL_IN:  cond_hit = in_xfer && in_data.is_final;
			C_SCAN_END:  cond_hit = scan_end;
			C_OUT_BLOCK: cond_hit = blocked;
			C_LAST_PASS: cond_hit = (pass_q == 2'(CLS_OTHER));
			default:     cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_wr)
			byte_mem[fill_q[AW-1:0]] <= in_data.char_in;
		if (uw.issue_rd)
			rd_q <= byte_mem[idx_q[AW-1:0]];
		if (load_out) begin
			out_q.char_out  <= rd_q;
			out_q.last_out  <= nxt_last;
			out_q.truncated <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_LOAD;
			fill_q      <= '0;
			idx_q       <= '0;
			emit_q      <= '0;
			pass_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= cond_hit ? uw.jmp_tgt : uw.nxt_tgt;
			if (in_xfer) begin
				if (store_wr)
					fill_q <= fill_q + CW'(1);
				else
					ovf_q <= 1'b1;
			end
			if (uw.test && !blocked)
				idx_q <= idx_q + CW'(1);
			if (load_out)
				emit_q <= emit_q + CW'(1);
			if (uw.end_pass) begin
				idx_q <= '0;
				if (pass_q == 2'(CLS_OTHER)) begin
					pass_q <= '0;
					fill_q <= '0;
					emit_q <= '0;
					ovf_q  <= 1'b0;
				end else begin
					pass_q <= pass_q + 2'd1;
				end
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CCSP_ASSERT_ALWAYS(a_fill_cap, fill_q <= CW'(MAX_LEN), "fill count above capacity")
	`CCSP_ASSERT(a_idx_range, idx_q <= fill_q, "scan index passed fill count")
	`CCSP_ASSERT(a_pass_range, pass_q <= 2'(CLS_OTHER), "pass counter out of range")
	`CCSP_ASSERT(a_out_hold, (out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)),
		"result changed while waiting for transfer")
	`CCSP_ASSERT(a_load_idle, in_ready |-> (idx_q == '0 && emit_q == '0 && pass_q == '0),
		"scan state not cleared while loading")

endmodule
